>>> hw/rtl/prnp_pkg.sv
`timescale 1ns / 1ps

package prnp_pkg;

  // Pilots per block.
  localparam int unsigned NumPilots = 64;
  localparam int unsigned CntW      = (NumPilots > 1) ? $clog2(NumPilots) : 1;
  // Floor of log2(NumPilots); equals log2 for a power of two.
  localparam int unsigned MeanShift = $clog2(NumPilots + 1) - 1;

  localparam int unsigned InW    = 16;  // Q2.13 input parts
  localparam int unsigned OpW    = 19;  // multiplier operand, also Q5.13 residual
  localparam int unsigned ProdW  = 2 * OpW;
  localparam int unsigned AccW   = 33;  // residual part before truncation, Q.26
  localparam int unsigned MagW   = 38;  // |e|^2
  localparam int unsigned SumW   = 44;  // accumulator
  localparam int unsigned NoiseW = 38;  // result

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_SQ0,
    ST_SQ1,
    ST_MAG,
    ST_ACC
  } state_e;

  typedef enum logic [2:0] {
    MUL_GR_PR,
    MUL_GI_PI,
    MUL_GR_PI,
    MUL_GI_PR,
    MUL_ER_ER,
    MUL_EI_EI
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_RE_INIT,
    ACC_RE_ADD,
    ACC_IM_INIT,
    ACC_IM_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    MAG_NONE,
    MAG_LOAD,
    MAG_ADD
  } mag_op_e;

  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    mag_op_e  mag_op;
    logic     sum_upd;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic last_pilot;
  } status_t;

  // Q.26 residual part to Q5.13: floor by arithmetic shift, then saturate.
  function automatic logic signed [OpW-1:0] quant_q5_13(input logic signed [AccW-1:0] v);
    logic signed [AccW-14:0] s;
    logic signed [OpW-1:0]   r;
    s = v[AccW-1:13];
    if (s[AccW-14] != s[AccW-15]) begin
      r = s[AccW-14] ? {1'b1, {(OpW-1){1'b0}}} : {1'b0, {(OpW-1){1'b1}}};
    end else begin
      r = s[OpW-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/prnp_datapath.sv
`timescale 1ns / 1ps

module prnp_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  prnp_pkg::cmd_t                  cmd_i,
  output prnp_pkg::status_t               status_o,
  input  logic signed [prnp_pkg::InW-1:0] rx_re_i,
  input  logic signed [prnp_pkg::InW-1:0] rx_im_i,
  input  logic signed [prnp_pkg::InW-1:0] gain_re_i,
  input  logic signed [prnp_pkg::InW-1:0] gain_im_i,
  input  logic signed [prnp_pkg::InW-1:0] pilot_re_i,
  input  logic signed [prnp_pkg::InW-1:0] pilot_im_i,
  output logic [prnp_pkg::NoiseW-1:0]     noise_power_o
);

  logic signed [prnp_pkg::InW-1:0]   rr_q, ri_q, gr_q, gi_q, pr_q, pi_q;
  logic signed [prnp_pkg::OpW-1:0]   op_a, op_b, er, ei;
  logic signed [prnp_pkg::ProdW-1:0] prod_d, prod_q;
  logic signed [prnp_pkg::AccW-1:0]  acc_re_d, acc_re_q, acc_im_d, acc_im_q, prod_acc;
  logic [prnp_pkg::MagW-1:0]         mag_d, mag_q, prod_sq;
  logic [prnp_pkg::SumW:0]           sum_wide;
  logic [prnp_pkg::SumW-1:0]         sum_next, sum_d, sum_q, sum_mean;
  logic [prnp_pkg::CntW-1:0]         count_d, count_q;
  logic [prnp_pkg::NoiseW-1:0]       noise_d, noise_q;

  function automatic logic signed [prnp_pkg::OpW-1:0] ext(
    input logic signed [prnp_pkg::InW-1:0] v);
    return {{(prnp_pkg::OpW - prnp_pkg::InW){v[prnp_pkg::InW-1]}}, v};
  endfunction

  function automatic logic signed [prnp_pkg::AccW-1:0] scale(
    input logic signed [prnp_pkg::InW-1:0] v);
    return {{(prnp_pkg::AccW - prnp_pkg::InW - 13){v[prnp_pkg::InW-1]}}, v, 13'b0};
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rr_q <= rx_re_i;
      ri_q <= rx_im_i;
      gr_q <= gain_re_i;
      gi_q <= gain_im_i;
      pr_q <= pilot_re_i;
      pi_q <= pilot_im_i;
    end
  end

  assign er = prnp_pkg::quant_q5_13(acc_re_q);
  assign ei = prnp_pkg::quant_q5_13(acc_im_q);

  // Shared multiplier, one product per cycle.
  always_comb begin
    case (cmd_i.mul_sel)
      prnp_pkg::MUL_GR_PR: begin op_a = ext(gr_q); op_b = ext(pr_q); end
      prnp_pkg::MUL_GI_PI: begin op_a = ext(gi_q); op_b = ext(pi_q); end
      prnp_pkg::MUL_GR_PI: begin op_a = ext(gr_q); op_b = ext(pi_q); end
      prnp_pkg::MUL_GI_PR: begin op_a = ext(gi_q); op_b = ext(pr_q); end
      prnp_pkg::MUL_ER_ER: begin op_a = er;        op_b = er;        end
      prnp_pkg::MUL_EI_EI: begin op_a = ei;        op_b = ei;        end
      default:             begin op_a = '0;        op_b = '0;        end
    endcase
  end

  assign prod_d   = op_a * op_b;
  assign prod_acc = prod_q[prnp_pkg::AccW-1:0];
  assign prod_sq  = {1'b0, prod_q[prnp_pkg::MagW-2:0]};

  always_comb begin
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    case (cmd_i.acc_op)
      prnp_pkg::ACC_RE_INIT: acc_re_d = scale(rr_q) - prod_acc;
      prnp_pkg::ACC_RE_ADD:  acc_re_d = acc_re_q + prod_acc;
      prnp_pkg::ACC_IM_INIT: acc_im_d = scale(ri_q) - prod_acc;
      prnp_pkg::ACC_IM_SUB:  acc_im_d = acc_im_q - prod_acc;
      default: ;
    endcase
  end

  always_comb begin
    case (cmd_i.mag_op)
      prnp_pkg::MAG_LOAD: mag_d = prod_sq;
      prnp_pkg::MAG_ADD:  mag_d = mag_q + prod_sq;
      default:            mag_d = mag_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
    mag_q    <= mag_d;
    noise_q  <= noise_d;
  end

  assign sum_wide = {1'b0, sum_q} + {{(prnp_pkg::SumW + 1 - prnp_pkg::MagW){1'b0}}, mag_q};
  assign sum_next = sum_wide[prnp_pkg::SumW] ? '1 : sum_wide[prnp_pkg::SumW-1:0];
  assign sum_mean = sum_next >> prnp_pkg::MeanShift;

  assign status_o.last_pilot =
      (count_q == prnp_pkg::CntW'(prnp_pkg::NumPilots - 1));

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    noise_d = noise_q;
    if (cmd_i.sum_upd) begin
      if (status_o.last_pilot) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_next;
        count_d = count_q + 1'b1;
      end
    end
    if (cmd_i.emit) begin
      noise_d = sum_mean[prnp_pkg::NoiseW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  assign noise_power_o = noise_q;

  a_block_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sum_upd && status_o.last_pilot) |=> (sum_q == '0 && count_q == '0))
    else $error("accumulator not cleared after the last pilot of a block");

endmodule

>>> hw/rtl/prnp_ctrl.sv
`timescale 1ns / 1ps

module prnp_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output prnp_pkg::cmd_t             cmd_o,
  input  prnp_pkg::status_t          status_i
);

  prnp_pkg::state_e state_d, state_q;
  logic             out_valid_d, out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prnp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.mul_sel = prnp_pkg::MUL_GR_PR;
    cmd_o.acc_op  = prnp_pkg::ACC_NONE;
    cmd_o.mag_op  = prnp_pkg::MAG_NONE;
    cmd_o.sum_upd = 1'b0;
    cmd_o.emit    = 1'b0;
    case (state_q)
      prnp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = prnp_pkg::ST_P0;
        end
      end
      prnp_pkg::ST_P0: begin
        cmd_o.mul_sel = prnp_pkg::MUL_GR_PR;
        state_d       = prnp_pkg::ST_P1;
      end
      prnp_pkg::ST_P1: begin
        cmd_o.mul_sel = prnp_pkg::MUL_GI_PI;
        cmd_o.acc_op  = prnp_pkg::ACC_RE_INIT;
        state_d       = prnp_pkg::ST_P2;
      end
      prnp_pkg::ST_P2: begin
        cmd_o.mul_sel = prnp_pkg::MUL_GR_PI;
        cmd_o.acc_op  = prnp_pkg::ACC_RE_ADD;
        state_d       = prnp_pkg::ST_P3;
      end
      prnp_pkg::ST_P3: begin
        cmd_o.mul_sel = prnp_pkg::MUL_GI_PR;
        cmd_o.acc_op  = prnp_pkg::ACC_IM_INIT;
        state_d       = prnp_pkg::ST_SQ0;
      end
      prnp_pkg::ST_SQ0: begin
        cmd_o.mul_sel = prnp_pkg::MUL_ER_ER;
        cmd_o.acc_op  = prnp_pkg::ACC_IM_SUB;
        state_d       = prnp_pkg::ST_SQ1;
      end
      prnp_pkg::ST_SQ1: begin
        cmd_o.mul_sel = prnp_pkg::MUL_EI_EI;
        cmd_o.mag_op  = prnp_pkg::MAG_LOAD;
        state_d       = prnp_pkg::ST_MAG;
      end
      prnp_pkg::ST_MAG: begin
        cmd_o.mag_op = prnp_pkg::MAG_ADD;
        state_d      = prnp_pkg::ST_ACC;
      end
      prnp_pkg::ST_ACC: begin
        // A closing pilot waits while the previous mean is still untaken.
        if (!(status_i.last_pilot && out_valid_q && !out_ready_i)) begin
          cmd_o.sum_upd = 1'b1;
          cmd_o.emit    = status_i.last_pilot;
          if (status_i.last_pilot) begin
            out_valid_d = 1'b1;
          end
          state_d = prnp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = prnp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == prnp_pkg::ST_P0))
    else $error("accepted pilot did not start the product sequence");

  a_emit_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (state_q == prnp_pkg::ST_ACC && status_i.last_pilot))
    else $error("mean emitted outside the closing pilot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("pending mean overwritten before its transfer");

endmodule

>>> hw/rtl/pilot_residual_noise_power_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// pilot     in         in_valid_i / in_ready_o    rx_*, gain_*, pilot_* (signed Q2.13)
// result    out        out_valid_o / out_ready_i  noise_power_o (unsigned, 26 frac bits)
//
// Each pilot passes through IDLE (the input transfer), P0 to P3, SQ0, SQ1, MAG and ACC; in P0
// to SQ1 one shared 19 x 19 multiplier forms the four real products of g * p and two squares.
// Input ready is high only while the block is idle, so that shared multiplier sets the rate.
// Reset clears the state machine, the pilot count and the accumulator; no clearing pass.
// A closing pilot waits in its last step while the previous mean has not been taken;
// otherwise the output register lets work continue while a result waits.

module pilot_residual_noise_power_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [prnp_pkg::InW-1:0] rx_re_i,
  input  logic signed [prnp_pkg::InW-1:0] rx_im_i,
  input  logic signed [prnp_pkg::InW-1:0] gain_re_i,
  input  logic signed [prnp_pkg::InW-1:0] gain_im_i,
  input  logic signed [prnp_pkg::InW-1:0] pilot_re_i,
  input  logic signed [prnp_pkg::InW-1:0] pilot_im_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [prnp_pkg::NoiseW-1:0]     noise_power_o
);

  // Commands flow from the controller to the datapath; the datapath reports only
  // whether the current pilot closes a block.
  prnp_pkg::cmd_t    cmd;
  prnp_pkg::status_t status;

  prnp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // The datapath forms the residual in Q.26, truncates it to Q5.13 with saturation,
  // and adds its squared magnitude into a saturating 44-bit accumulator. The mean is
  // the accumulator shifted right by log2 of the block length.
  prnp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .rx_re_i       (rx_re_i),
    .rx_im_i       (rx_im_i),
    .gain_re_i     (gain_re_i),
    .gain_im_i     (gain_im_i),
    .pilot_re_i    (pilot_re_i),
    .pilot_im_i    (pilot_im_i),
    .noise_power_o (noise_power_o)
  );

endmodule
